>>> rtl/cau_pkg.sv
// Shared constants and codes for the complex arithmetic unit.
`timescale 1ns / 1ps
package cau_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_SAT = 2'd1,
      ST_DZ  = 2'd2,
      ST_RSV = 2'd3
   } status_type;

endpackage

>>> rtl/cau_req_if.sv
// Request and response channel interfaces of the complex arithmetic unit.
`timescale 1ns / 1ps
interface cau_req_if import cau_pkg::*; #(parameter int WORD_BITS = WORD_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic [1:0]                  operation;
   logic signed [WORD_BITS-1:0] a_real;
   logic signed [WORD_BITS-1:0] a_imag;
   logic signed [WORD_BITS-1:0] b_real;
   logic signed [WORD_BITS-1:0] b_imag;

   modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
   modport sink (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if import cau_pkg::*; #(parameter int WORD_BITS = WORD_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] res_real;
   logic signed [WORD_BITS-1:0] res_imag;
   logic [1:0]                  status;

   modport source (output valid, res_real, res_imag, status, input ready);
   modport sink (input valid, res_real, res_imag, status, output ready);
endinterface

>>> rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide on signed fixed point.
// Latency is the same for all ops.
// Throughput: one transaction per cycle unless stalled; quotient bits come one per stage.
// Stall: the whole pipe holds while the output register is full and not taken.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_ch,
   cau_rsp_if.source  rsp_ch
);
   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;          // product width
   localparam int SW = PW + 1;         // sum of two products
   localparam int RW = 3 * W + F + 1;  // divider remainder
   localparam int NS = W + 1;          // divide steps: overflow check plus W quotient bits

   // Saturate a magnitude with sign; top bit of result flags a clamp.
   function automatic logic [W:0] sat_fn(input logic neg, input logic [SW-1:0] mag);
      logic [SW-1:0] lim;
      logic [W-1:0]  w;
      logic          ov;
      lim = neg ? (SW'(1) << (W - 1)) : ((SW'(1) << (W - 1)) - SW'(1));
      ov  = mag > lim;
      w   = ov ? lim[W-1:0] : mag[W-1:0];
      if (neg) begin
         w = -w;
      end
      return {ov, w};
   endfunction

   logic adv;

   // Stage 1: input register
   logic                s1_vld_ff;
   logic [1:0]          s1_op_ff;
   logic signed [W-1:0] s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff;

   // Stage 2: products and plain sums
   logic                 s2_vld_ff;
   logic [1:0]           s2_op_ff;
   logic                 s2_dz_ff;
   logic signed [PW-1:0] s2_ac_ff, s2_bd_ff, s2_ad_ff, s2_bc_ff, s2_cc_ff, s2_dd_ff;
   logic signed [W:0]    s2_re_ff, s2_im_ff;

   // Stage 3: combined parts and divisor
   logic                 s3_vld_ff;
   logic [1:0]           s3_op_ff;
   logic                 s3_dz_ff;
   logic signed [SW-1:0] s3_re_ff, s3_im_ff;
   logic [PW-1:0]        s3_den_ff;

   // Divide pipe, index 0 is stage 4 output
   logic          dv_vld_ff  [NS+1];
   logic          dv_div_ff  [NS+1];
   logic          dv_dz_ff   [NS+1];
   logic          dv_nre_ff  [NS+1];
   logic          dv_nim_ff  [NS+1];
   logic          dv_bre_ff  [NS+1];
   logic          dv_bim_ff  [NS+1];
   logic          dv_sat_ff  [NS+1];
   logic [W-1:0]  dv_qre_ff  [NS+1];
   logic [W-1:0]  dv_qim_ff  [NS+1];
   logic [W-1:0]  dv_rre_ff  [NS+1];   // final word for add, sub, mul
   logic [W-1:0]  dv_rim_ff  [NS+1];
   logic [RW-1:0] dv_mre_ff  [NS+1];   // remainders
   logic [RW-1:0] dv_mim_ff  [NS+1];
   logic [PW-1:0] dv_den_ff  [NS+1];

   logic [RW-1:0] step_mre [NS];
   logic [RW-1:0] step_mim [NS];
   logic          step_gre [NS];
   logic          step_gim [NS];

   // Output register
   logic         out_vld_ff;
   logic [W-1:0] out_re_ff, out_im_ff;
   logic [1:0]   out_st_ff;

   // Stall only when a finished result is not taken
   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   assign rsp_ch.valid    = out_vld_ff;
   assign rsp_ch.res_real = out_re_ff;
   assign rsp_ch.res_imag = out_im_ff;
   assign rsp_ch.status   = out_st_ff;

   // Stage 4 combinational: magnitude, truncating shift, clamp, divider setup
   logic [SW-1:0] s4_mre, s4_mim, s4_shre, s4_shim;
   logic [W:0]    s4_satre, s4_satim;
   always_comb begin
      s4_mre  = s3_re_ff[SW-1] ? SW'(-s3_re_ff) : SW'(s3_re_ff);
      s4_mim  = s3_im_ff[SW-1] ? SW'(-s3_im_ff) : SW'(s3_im_ff);
      s4_shre = (s3_op_ff == OP_MUL) ? (s4_mre >> F) : s4_mre;
      s4_shim = (s3_op_ff == OP_MUL) ? (s4_mim >> F) : s4_mim;
      s4_satre = sat_fn(s3_re_ff[SW-1], s4_shre);
      s4_satim = sat_fn(s3_im_ff[SW-1], s4_shim);
   end

   // One step per stage; first step only checks for quotient overflow
   for (genvar j = 0; j < NS; j++) begin : g_step
      cau_div_step #(.RW(RW), .DW(PW), .SHIFT(W - j)) u_re (
         .rem_i (dv_mre_ff[j]),
         .den_i (dv_den_ff[j]),
         .rem_o (step_mre[j]),
         .ge_o  (step_gre[j])
      );
      cau_div_step #(.RW(RW), .DW(PW), .SHIFT(W - j)) u_im (
         .rem_i (dv_mim_ff[j]),
         .den_i (dv_den_ff[j]),
         .rem_o (step_mim[j]),
         .ge_o  (step_gim[j])
      );
   end

   // Final stage combinational: clamp quotient and pick status
   logic [W:0]   fin_re, fin_im;
   logic [W-1:0] fin_wre, fin_wim;
   logic [1:0]   fin_st;
   always_comb begin
      fin_re = sat_fn(dv_nre_ff[NS],
                      dv_bre_ff[NS] ? {SW{1'b1}} : SW'(dv_qre_ff[NS]));
      fin_im = sat_fn(dv_nim_ff[NS],
                      dv_bim_ff[NS] ? {SW{1'b1}} : SW'(dv_qim_ff[NS]));
      fin_wre = dv_rre_ff[NS];
      fin_wim = dv_rim_ff[NS];
      fin_st  = dv_sat_ff[NS] ? ST_SAT : ST_OK;
      if (dv_div_ff[NS]) begin
         if (dv_dz_ff[NS]) begin
            fin_wre = '0;
            fin_wim = '0;
            fin_st  = ST_DZ;
         end else begin
            fin_wre = fin_re[W-1:0];
            fin_wim = fin_im[W-1:0];
            fin_st  = (fin_re[W] || fin_im[W]) ? ST_SAT : ST_OK;
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int j = 0; j <= NS; j++) begin
            dv_vld_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         s1_vld_ff    <= req_ch.valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         dv_vld_ff[0] <= s3_vld_ff;
         for (int j = 0; j < NS; j++) begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         out_vld_ff <= dv_vld_ff[NS];
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff <= req_ch.operation;
         s1_a_ff  <= req_ch.a_real;
         s1_b_ff  <= req_ch.a_imag;
         s1_c_ff  <= req_ch.b_real;
         s1_d_ff  <= req_ch.b_imag;

         s2_op_ff <= s1_op_ff;
         s2_dz_ff <= (s1_c_ff == '0) && (s1_d_ff == '0);
         s2_ac_ff <= PW'(s1_a_ff) * PW'(s1_c_ff);
         s2_bd_ff <= PW'(s1_b_ff) * PW'(s1_d_ff);
         s2_ad_ff <= PW'(s1_a_ff) * PW'(s1_d_ff);
         s2_bc_ff <= PW'(s1_b_ff) * PW'(s1_c_ff);
         s2_cc_ff <= PW'(s1_c_ff) * PW'(s1_c_ff);
         s2_dd_ff <= PW'(s1_d_ff) * PW'(s1_d_ff);
         if (s1_op_ff == OP_SUB) begin
            s2_re_ff <= (W+1)'(s1_a_ff) - (W+1)'(s1_c_ff);
            s2_im_ff <= (W+1)'(s1_b_ff) - (W+1)'(s1_d_ff);
         end else begin
            s2_re_ff <= (W+1)'(s1_a_ff) + (W+1)'(s1_c_ff);
            s2_im_ff <= (W+1)'(s1_b_ff) + (W+1)'(s1_d_ff);
         end

         s3_op_ff  <= s2_op_ff;
         s3_dz_ff  <= s2_dz_ff;
         s3_den_ff <= PW'(s2_cc_ff) + PW'(s2_dd_ff);
         unique case (s2_op_ff)
            OP_MUL: begin
               s3_re_ff <= SW'(s2_ac_ff) - SW'(s2_bd_ff);
               s3_im_ff <= SW'(s2_ad_ff) + SW'(s2_bc_ff);
            end
            OP_DIV: begin
               s3_re_ff <= SW'(s2_ac_ff) + SW'(s2_bd_ff);
               s3_im_ff <= SW'(s2_bc_ff) - SW'(s2_ad_ff);
            end
            default: begin
               s3_re_ff <= SW'(s2_re_ff);
               s3_im_ff <= SW'(s2_im_ff);
            end
         endcase

         // Stage 4: dividend is magnitude scaled by the fraction bits
         dv_div_ff[0] <= (s3_op_ff == OP_DIV);
         dv_dz_ff[0]  <= s3_dz_ff;
         dv_nre_ff[0] <= s3_re_ff[SW-1];
         dv_nim_ff[0] <= s3_im_ff[SW-1];
         dv_bre_ff[0] <= 1'b0;
         dv_bim_ff[0] <= 1'b0;
         dv_qre_ff[0] <= '0;
         dv_qim_ff[0] <= '0;
         dv_rre_ff[0] <= s4_satre[W-1:0];
         dv_rim_ff[0] <= s4_satim[W-1:0];
         dv_sat_ff[0] <= s4_satre[W] || s4_satim[W];
         dv_mre_ff[0] <= RW'(s4_mre) << F;
         dv_mim_ff[0] <= RW'(s4_mim) << F;
         dv_den_ff[0] <= s3_den_ff;

         for (int j = 0; j < NS; j++) begin
            dv_div_ff[j+1] <= dv_div_ff[j];
            dv_dz_ff[j+1]  <= dv_dz_ff[j];
            dv_nre_ff[j+1] <= dv_nre_ff[j];
            dv_nim_ff[j+1] <= dv_nim_ff[j];
            dv_rre_ff[j+1] <= dv_rre_ff[j];
            dv_rim_ff[j+1] <= dv_rim_ff[j];
            dv_sat_ff[j+1] <= dv_sat_ff[j];
            dv_den_ff[j+1] <= dv_den_ff[j];
            dv_mre_ff[j+1] <= step_mre[j];
            dv_mim_ff[j+1] <= step_mim[j];
            if (j == 0) begin
               dv_bre_ff[j+1] <= step_gre[j];
               dv_bim_ff[j+1] <= step_gim[j];
               dv_qre_ff[j+1] <= dv_qre_ff[j];
               dv_qim_ff[j+1] <= dv_qim_ff[j];
            end else begin
               dv_bre_ff[j+1] <= dv_bre_ff[j];
               dv_bim_ff[j+1] <= dv_bim_ff[j];
               dv_qre_ff[j+1] <= dv_qre_ff[j] | (W'(step_gre[j]) << (W - j));
               dv_qim_ff[j+1] <= dv_qim_ff[j] | (W'(step_gim[j]) << (W - j));
            end
         end

         out_re_ff <= fin_wre;
         out_im_ff <= fin_wim;
         out_st_ff <= fin_st;
      end
   end
endmodule

>>> rtl/cau_div_step.sv
// One restoring divide step: compare remainder with shifted divisor, subtract.
`timescale 1ns / 1ps
module cau_div_step import cau_pkg::*; #(
   parameter int RW    = 113,
   parameter int DW    = 64,
   parameter int SHIFT = 0
) (
   input  logic [RW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   output logic [RW-1:0] rem_o,
   output logic          ge_o
);
   logic [RW-1:0] dsh;

   assign dsh   = RW'(den_i) << SHIFT;
   assign ge_o  = rem_i >= dsh;
   assign rem_o = ge_o ? (rem_i - dsh) : rem_i;
endmodule
